@@ hw/rtl/kb4fp_pkg.sv @@
// shared constants and arithmetic helpers for the kb4 fisheye projection pipeline
`default_nettype none
package kb4fp_pkg;

  localparam int CW = 52;
  localparam int ZW = 33;
  localparam int PW = 40;
  localparam int OW = 46;

  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 33'sd843314856;
      1: r = 33'sd497837829;
      2: r = 33'sd263043836;
      3: r = 33'sd133525158;
      4: r = 33'sd67021686;
      5: r = 33'sd33543515;
      6: r = 33'sd16775850;
      7: r = 33'sd8388437;
      8: r = 33'sd4194282;
      9: r = 33'sd2097149;
      default: begin
        if (i <= 30) r = signed'(ZW'((64'd1 << (30 - i)) - 64'd1));
        else r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [PW-1:0] mag40(input logic signed [PW-1:0] a);
    logic [PW-1:0] r;
    r = a[PW-1] ? PW'(-a) : PW'(a);
    return r;
  endfunction

  // combine partial products, shift and truncate toward zero
  function automatic logic signed [OW-1:0] mul_fin(input logic [63:0] pl,
                                                   input logic [PW-1:0] ph,
                                                   input logic neg, input int sh);
    logic [71:0] prod;
    logic [OW-1:0] mag;
    logic signed [OW-1:0] r;
    prod = {ph[39:0], 32'b0} + {8'b0, pl};
    mag = OW'(prod >> sh);
    r = neg ? signed'(-mag) : signed'(mag);
    return r;
  endfunction

  // clip to signed 32 bits, flag in the top bit
  function automatic logic [32:0] sat32(input logic signed [OW:0] v);
    logic [32:0] r;
    if (v > 47'sd2147483647) r = {1'b1, 32'h7fffffff};
    else if (v < -47'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/kb4_fisheye_projection_top.sv @@
// kb4 fisheye projection: fully pipelined fixed-point point-to-pixel mapper
// One word per clock in and out while the output is not stalled. The pipeline holds the
// 32-stage square root, the 31-stage divider and one cordic stage per iteration. A stall
// on the output freezes the whole pipeline. Write the configuration only while the
// pipeline is empty.
`default_nettype none
module kb4_fisheye_projection_top #(
  parameter int ATAN_ITERATIONS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [63:0] s_tdata,   // point_x, point_y
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [63:0] m_tdata,   // pixel_u, pixel_v
  output      logic [0:0]  m_tuser    // saturated
);
  localparam int CW = kb4fp_pkg::CW;
  localparam int ZW = kb4fp_pkg::ZW;
  localparam int PW = kb4fp_pkg::PW;
  localparam int OW = kb4fp_pkg::OW;
  localparam int N  = ATAN_ITERATIONS;

  localparam logic [7:0] REG_FOCAL_X  = 8'd0;
  localparam logic [7:0] REG_FOCAL_Y  = 8'd1;
  localparam logic [7:0] REG_CENTRE_X = 8'd2;
  localparam logic [7:0] REG_CENTRE_Y = 8'd3;
  localparam logic [7:0] REG_K1       = 8'd4;
  localparam logic [7:0] REG_K2       = 8'd5;
  localparam logic [7:0] REG_K3       = 8'd6;
  localparam logic [7:0] REG_K4       = 8'd7;

  logic [31:0] focal_x, focal_y;
  logic signed [31:0] centre_x, centre_y, coeff_k1, coeff_k2, coeff_k3, coeff_k4;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x  <= 32'd65536;
      focal_y  <= 32'd65536;
      centre_x <= '0;
      centre_y <= '0;
      coeff_k1 <= '0;
      coeff_k2 <= '0;
      coeff_k3 <= '0;
      coeff_k4 <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FOCAL_X:  focal_x  <= cfg_data;
        REG_FOCAL_Y:  focal_y  <= cfg_data;
        REG_CENTRE_X: centre_x <= cfg_data;
        REG_CENTRE_Y: centre_y <= cfg_data;
        REG_K1:       coeff_k1 <= cfg_data;
        REG_K2:       coeff_k2 <= cfg_data;
        REG_K3:       coeff_k3 <= cfg_data;
        REG_K4:       coeff_k4 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // input and squaring
  logic v_a, v_b;
  logic signed [31:0] x_a, y_a, x_b, y_b;
  logic [31:0] ax_a, ay_a;
  logic [63:0] sqx_b, sqy_b;

  assign ax_a = x_a[31] ? 32'(-x_a) : 32'(x_a);
  assign ay_a = y_a[31] ? 32'(-y_a) : 32'(y_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
    end else if (en) begin
      v_a <= s_tvalid;
      v_b <= v_a;
    end
    if (en) begin
      x_a   <= s_tdata[31:0];
      y_a   <= s_tdata[63:32];
      x_b   <= x_a;
      y_b   <= y_a;
      sqx_b <= ax_a * ax_a;
      sqy_b <= ay_a * ay_a;
    end
  end

  // square root, one result bit per stage
  logic        sv    [0:32];
  logic [63:0] srem  [0:32];
  logic [31:0] sroot [0:32];
  logic signed [31:0] sxs [0:32];
  logic signed [31:0] sys [0:32];

  assign sv[0]    = v_b;
  assign srem[0]  = sqx_b + sqy_b;
  assign sroot[0] = '0;
  assign sxs[0]   = x_b;
  assign sys[0]   = y_b;

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam int K = 31 - j;
    logic [65:0] t;
    logic ge;
    assign t  = ({34'b0, sroot[j]} << (K + 1)) | (66'd1 << (2 * K));
    assign ge = {2'b0, srem[j]} >= t;
    always_ff @(posedge clk) begin
      if (rst) sv[j+1] <= 1'b0;
      else if (en) sv[j+1] <= sv[j];
      if (en) begin
        srem[j+1]  <= ge ? srem[j] - t[63:0] : srem[j];
        sroot[j+1] <= ge ? (sroot[j] | (32'd1 << K)) : sroot[j];
        sxs[j+1]   <= sxs[j];
        sys[j+1]   <= sys[j];
      end
    end
  end

  // coord / r, one quotient bit per stage, both axes
  logic        dv    [0:31];
  logic [63:0] dremx [0:31];
  logic [63:0] dremy [0:31];
  logic [30:0] dqx   [0:31];
  logic [30:0] dqy   [0:31];
  logic [31:0] dr    [0:31];
  logic        dnx   [0:31];
  logic        dny   [0:31];
  logic        dz    [0:31];
  logic [31:0] mx0, my0;

  assign mx0      = sxs[32][31] ? 32'(-sxs[32]) : 32'(sxs[32]);
  assign my0      = sys[32][31] ? 32'(-sys[32]) : 32'(sys[32]);
  assign dv[0]    = sv[32];
  assign dremx[0] = {2'b0, mx0, 30'b0};
  assign dremy[0] = {2'b0, my0, 30'b0};
  assign dqx[0]   = '0;
  assign dqy[0]   = '0;
  assign dr[0]    = sroot[32];
  assign dnx[0]   = sxs[32][31];
  assign dny[0]   = sys[32][31];
  assign dz[0]    = sroot[32] == 32'd0;

  for (genvar n = 0; n < 31; n++) begin : g_div
    localparam int B = 30 - n;
    logic [63:0] dd;
    logic gx, gy;
    assign dd = {32'b0, dr[n]} << B;
    assign gx = dremx[n] >= dd;
    assign gy = dremy[n] >= dd;
    always_ff @(posedge clk) begin
      if (rst) dv[n+1] <= 1'b0;
      else if (en) dv[n+1] <= dv[n];
      if (en) begin
        dremx[n+1] <= gx ? dremx[n] - dd : dremx[n];
        dremy[n+1] <= gy ? dremy[n] - dd : dremy[n];
        dqx[n+1]   <= gx ? (dqx[n] | (31'd1 << B)) : dqx[n];
        dqy[n+1]   <= gy ? (dqy[n] | (31'd1 << B)) : dqy[n];
        dr[n+1]    <= dr[n];
        dnx[n+1]   <= dnx[n];
        dny[n+1]   <= dny[n];
        dz[n+1]    <= dz[n];
      end
    end
  end

  // cordic vectoring for atan(r)
  logic                 cv  [0:N];
  logic signed [CW-1:0] ccx [0:N];
  logic signed [CW-1:0] ccy [0:N];
  logic signed [ZW-1:0] ccz [0:N];
  logic signed [31:0]   csx [0:N];
  logic signed [31:0]   csy [0:N];
  logic                 cze [0:N];

  assign cv[0]  = dv[31];
  assign ccx[0] = {11'b0, 1'b1, 40'b0};
  assign ccy[0] = {4'b0, dr[31], 16'b0};
  assign ccz[0] = '0;
  assign csx[0] = dnx[31] ? signed'(-{1'b0, dqx[31]}) : signed'({1'b0, dqx[31]});
  assign csy[0] = dny[31] ? signed'(-{1'b0, dqy[31]}) : signed'({1'b0, dqy[31]});
  assign cze[0] = dz[31];

  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] st;
    assign xs = ccx[i] >>> i;
    assign ys = ccy[i] >>> i;
    assign st = kb4fp_pkg::atan_step(i);
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (en) cv[i+1] <= cv[i];
      if (en) begin
        if (!ccy[i][CW-1]) begin
          ccx[i+1] <= ccx[i] + ys;
          ccy[i+1] <= ccy[i] - xs;
          ccz[i+1] <= ccz[i] + st;
        end else begin
          ccx[i+1] <= ccx[i] - ys;
          ccy[i+1] <= ccy[i] + xs;
          ccz[i+1] <= ccz[i] - st;
        end
        csx[i+1] <= csx[i];
        csy[i+1] <= csy[i];
        cze[i+1] <= cze[i];
      end
    end
  end

  // theta and theta squared
  logic        tv, tze;
  logic [30:0] th;
  logic [61:0] tsq;
  logic signed [31:0] tsx, tsy;
  logic [30:0] th_c;

  assign th_c = ccz[N][ZW-1] ? 31'd0 : ccz[N][30:0];

  always_ff @(posedge clk) begin
    if (rst) tv <= 1'b0;
    else if (en) tv <= cv[N];
    if (en) begin
      th  <= th_c;
      tsq <= th_c * th_c;
      tsx <= csx[N];
      tsy <= csy[N];
      tze <= cze[N];
    end
  end

  // horner polynomial, two stages per step
  logic                 hv  [0:4];
  logic signed [PW-1:0] hp  [0:4];
  logic [30:0]          hth [0:4];
  logic [31:0]          ht2 [0:4];
  logic signed [31:0]   hsx [0:4];
  logic signed [31:0]   hsy [0:4];
  logic                 hze [0:4];
  logic                 av  [0:3];
  logic [63:0]          apl [0:3];
  logic [PW-1:0]        aph [0:3];
  logic                 ang [0:3];
  logic [30:0]          ath [0:3];
  logic [31:0]          at2 [0:3];
  logic signed [31:0]   asx [0:3];
  logic signed [31:0]   asy [0:3];
  logic                 aze [0:3];
  logic signed [PW-1:0] coef [0:3];

  assign coef[0] = PW'(coeff_k3);
  assign coef[1] = PW'(coeff_k2);
  assign coef[2] = PW'(coeff_k1);
  assign coef[3] = signed'(PW'(1) << 28);

  assign hv[0]  = tv;
  assign hp[0]  = PW'(coeff_k4);
  assign hth[0] = th;
  assign ht2[0] = tsq[61:30];
  assign hsx[0] = tsx;
  assign hsy[0] = tsy;
  assign hze[0] = tze;

  for (genvar h = 0; h < 4; h++) begin : g_horner
    logic [PW-1:0] pm;
    assign pm = kb4fp_pkg::mag40(hp[h]);
    always_ff @(posedge clk) begin
      if (rst) begin
        av[h]   <= 1'b0;
        hv[h+1] <= 1'b0;
      end else if (en) begin
        av[h]   <= hv[h];
        hv[h+1] <= av[h];
      end
      if (en) begin
        apl[h] <= pm[31:0] * ht2[h];
        aph[h] <= pm[39:32] * ht2[h];
        ang[h] <= hp[h][PW-1];
        ath[h] <= hth[h];
        at2[h] <= ht2[h];
        asx[h] <= hsx[h];
        asy[h] <= hsy[h];
        aze[h] <= hze[h];
        hp[h+1]  <= coef[h] + signed'(PW'(kb4fp_pkg::mul_fin(apl[h], aph[h], ang[h], 30)));
        hth[h+1] <= ath[h];
        ht2[h+1] <= at2[h];
        hsx[h+1] <= asx[h];
        hsy[h+1] <= asy[h];
        hze[h+1] <= aze[h];
      end
    end
  end

  // rd = p * theta, then m = s * rd, then focal * m
  logic [PW-1:0] pm4, rdm, mxm, mym;
  logic [31:0]   sxm, sym;
  logic          ra_v, rb_v, ma_v, mb_v, oa_v, ob_v;
  logic [63:0]   ra_pl, max_pl, may_pl, oax_pl, oay_pl;
  logic [PW-1:0] ra_ph, max_ph, may_ph, oax_ph, oay_ph;
  logic          ra_ng, max_ng, may_ng, oax_ng, oay_ng;
  logic signed [31:0] ra_sx, ra_sy, rb_sx, rb_sy;
  logic          ra_z, rb_z, ma_z, mb_z, oa_z, ob_z;
  logic signed [PW-1:0] rd, mx, my;
  logic signed [OW-1:0] ox, oy;

  assign pm4 = kb4fp_pkg::mag40(hp[4]);
  assign rdm = kb4fp_pkg::mag40(rd);
  assign sxm = rb_sx[31] ? 32'(-rb_sx) : 32'(rb_sx);
  assign sym = rb_sy[31] ? 32'(-rb_sy) : 32'(rb_sy);
  assign mxm = kb4fp_pkg::mag40(mx);
  assign mym = kb4fp_pkg::mag40(my);

  always_ff @(posedge clk) begin
    if (rst) begin
      ra_v <= 1'b0;
      rb_v <= 1'b0;
      ma_v <= 1'b0;
      mb_v <= 1'b0;
      oa_v <= 1'b0;
      ob_v <= 1'b0;
    end else if (en) begin
      ra_v <= hv[4];
      rb_v <= ra_v;
      ma_v <= rb_v;
      mb_v <= ma_v;
      oa_v <= mb_v;
      ob_v <= oa_v;
    end
    if (en) begin
      ra_pl <= pm4[31:0] * {1'b0, hth[4]};
      ra_ph <= pm4[39:32] * {1'b0, hth[4]};
      ra_ng <= hp[4][PW-1];
      ra_sx <= hsx[4];
      ra_sy <= hsy[4];
      ra_z  <= hze[4];
      rd    <= PW'(kb4fp_pkg::mul_fin(ra_pl, ra_ph, ra_ng, 30));
      rb_sx <= ra_sx;
      rb_sy <= ra_sy;
      rb_z  <= ra_z;
      max_pl <= rdm[31:0] * sxm;
      max_ph <= rdm[39:32] * sxm;
      max_ng <= rd[PW-1] ^ rb_sx[31];
      may_pl <= rdm[31:0] * sym;
      may_ph <= rdm[39:32] * sym;
      may_ng <= rd[PW-1] ^ rb_sy[31];
      ma_z   <= rb_z;
      mx     <= PW'(kb4fp_pkg::mul_fin(max_pl, max_ph, max_ng, 30));
      my     <= PW'(kb4fp_pkg::mul_fin(may_pl, may_ph, may_ng, 30));
      mb_z   <= ma_z;
      oax_pl <= mxm[31:0] * focal_x;
      oax_ph <= mxm[39:32] * focal_x;
      oax_ng <= mx[PW-1];
      oay_pl <= mym[31:0] * focal_y;
      oay_ph <= mym[39:32] * focal_y;
      oay_ng <= my[PW-1];
      oa_z   <= mb_z;
      ox     <= kb4fp_pkg::mul_fin(oax_pl, oax_ph, oax_ng, 28);
      oy     <= kb4fp_pkg::mul_fin(oay_pl, oay_ph, oay_ng, 28);
      ob_z   <= oa_z;
    end
  end

  // centre offset, clipping and output word
  logic [32:0] fu, fv;
  assign fu = kb4fp_pkg::sat32((OW+1)'(ox) + (OW+1)'(centre_x));
  assign fv = kb4fp_pkg::sat32((OW+1)'(oy) + (OW+1)'(centre_y));

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= ob_v;
    if (en) begin
      if (ob_z) begin
        m_tdata <= {centre_y, centre_x};
        m_tuser <= 1'b0;
      end else begin
        m_tdata <= {fv[31:0], fu[31:0]};
        m_tuser <= fu[32] | fv[32];
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/kb4_tb_pkg.sv @@
// register indexes shared by the fisheye projection testbench files
package kb4_tb_pkg;

  typedef enum logic [7:0] {
    REG_FOCAL_X  = 8'd0,
    REG_FOCAL_Y  = 8'd1,
    REG_CENTRE_X = 8'd2,
    REG_CENTRE_Y = 8'd3,
    REG_COEFF_K1 = 8'd4,
    REG_COEFF_K2 = 8'd5,
    REG_COEFF_K3 = 8'd6,
    REG_COEFF_K4 = 8'd7,
    REG_UNMAPPED = 8'd9
  } kb4_reg_e;

endpackage

@@ tb/sv/kb4_projection_checker.sv @@
// checker: predicts projected pixels from accepted points and compares the output words
module kb4_projection_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [63:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [63:0] m_tdata,
  input  wire logic [0:0]  m_tuser,
  output int               errors,
  output int               pending
);
  import kb4_tb_pkg::*;

  localparam int ATAN_STEPS = 24;

  typedef struct {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               saturated;
  } pixel_t;

  pixel_t pixel_q[$];
  logic [31:0] focal_x, focal_y, centre_x, centre_y, k1, k2, k3, k4;

  assign pending = pixel_q.size();

  function automatic longint mul_shift(longint a, longint b, int sh);
    logic [127:0] prod;
    logic [127:0] shifted;
    longint unsigned ua, ub, mag;
    logic neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? 64'd0 - 64'(a) : 64'(a);
    ub = b < 0 ? 64'd0 - 64'(b) : 64'(b);
    prod = 128'(ua) * 128'(ub);
    shifted = prod >> sh;
    if (shifted[127:63] != 0) mag = 64'h7fff_ffff_ffff_ffff;
    else mag = shifted[63:0];
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint atan_angle(int i);
    longint head [10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                          33543515, 16775850, 8388437, 4194282, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return (longint'(1) << (30 - i)) - 1;
    return 0;
  endfunction

  function automatic longint arctan_q30(longint unsigned r);
    longint vx, vy, z, xs, ys;
    vx = longint'(1) << 40;
    vy = longint'(r << 16);
    z = 0;
    for (int i = 0; i < ATAN_STEPS; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy >= 0) begin
        vx += ys;
        vy -= xs;
        z += atan_angle(i);
      end else begin
        vx -= ys;
        vy += xs;
        z -= atan_angle(i);
      end
    end
    return z < 0 ? 0 : z;
  endfunction

  function automatic longint axis_pixel(longint coord, longint unsigned r, longint rd,
                                        logic [31:0] focal, longint centre);
    longint unsigned mag;
    longint s, m;
    mag = coord < 0 ? 64'(-coord) : 64'(coord);
    s = longint'((mag << 30) / r);
    if (coord < 0) s = -s;
    m = mul_shift(s, rd, 30);
    return mul_shift(longint'({32'd0, focal}), m, 28) + centre;
  endfunction

  function automatic logic signed [31:0] clip32(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic pixel_t project_point(logic signed [31:0] px, logic signed [31:0] py);
    pixel_t res;
    longint x, y, theta, t2, p, rd;
    longint unsigned ax, ay, r;
    logic sat;
    x = px;
    y = py;
    ax = x < 0 ? 64'(-x) : 64'(x);
    ay = y < 0 ? 64'(-y) : 64'(y);
    r = int_sqrt(ax * ax + ay * ay);
    sat = 1'b0;
    if (r == 0) begin
      res.pixel_u = centre_x;
      res.pixel_v = centre_y;
      res.saturated = 1'b0;
      return res;
    end
    theta = arctan_q30(r);
    t2 = mul_shift(theta, theta, 30);
    p = longint'(signed'(k4));
    p = longint'(signed'(k3)) + mul_shift(p, t2, 30);
    p = longint'(signed'(k2)) + mul_shift(p, t2, 30);
    p = longint'(signed'(k1)) + mul_shift(p, t2, 30);
    p = (longint'(1) << 28) + mul_shift(p, t2, 30);
    rd = mul_shift(p, theta, 30);
    res.pixel_u = clip32(axis_pixel(x, r, rd, focal_x, longint'(signed'(centre_x))), sat);
    res.pixel_v = clip32(axis_pixel(y, r, rd, focal_y, longint'(signed'(centre_y))), sat);
    res.saturated = sat;
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      focal_x <= 32'd65536;
      focal_y <= 32'd65536;
      centre_x <= '0;
      centre_y <= '0;
      k1 <= '0;
      k2 <= '0;
      k3 <= '0;
      k4 <= '0;
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FOCAL_X:  focal_x <= cfg_data;
          REG_FOCAL_Y:  focal_y <= cfg_data;
          REG_CENTRE_X: centre_x <= cfg_data;
          REG_CENTRE_Y: centre_y <= cfg_data;
          REG_COEFF_K1: k1 <= cfg_data;
          REG_COEFF_K2: k2 <= cfg_data;
          REG_COEFF_K3: k3 <= cfg_data;
          REG_COEFF_K4: k4 <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        pixel_q.push_back(project_point(s_tdata[31:0], s_tdata[63:32]));
      if (m_tvalid && m_tready) begin
        if (pixel_q.size() == 0) begin
          $error("output word with no point pending");
          errors <= errors + 1;
        end else begin
          want = pixel_q.pop_front();
          if (m_tdata[31:0] !== want.pixel_u || m_tdata[63:32] !== want.pixel_v ||
              m_tuser[0] !== want.saturated) begin
            if (m_tdata[31:0] !== want.pixel_u)
              $error("pixel_u: expected %0d, got %0d", want.pixel_u, $signed(m_tdata[31:0]));
            if (m_tdata[63:32] !== want.pixel_v)
              $error("pixel_v: expected %0d, got %0d", want.pixel_v, $signed(m_tdata[63:32]));
            if (m_tuser[0] !== want.saturated)
              $error("saturated: expected %0d, got %0d", want.saturated, m_tuser[0]);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// testbench top: drives points and register writes into the fisheye projection block
module testbench;
  import kb4_tb_pkg::*;

  localparam int DRAIN_CYCLES = 130;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  int          errors, pending;
  int          tx_idle = 0, rx_idle = 0;
  int          cycles = 0;

  always #2 clk = ~clk;

  kb4_fisheye_projection_top u_top (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  kb4_projection_checker u_checker (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .errors, .pending
  );

  always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_idle);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = {py, px};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly view-plane points within a few units, sometimes anything
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
  endfunction

  task automatic load_lens(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx, logic [31:0] cy,
                           logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTRE_X, cx);
    write_reg(REG_CENTRE_Y, cy);
    write_reg(REG_COEFF_K1, a);
    write_reg(REG_COEFF_K2, b);
    write_reg(REG_COEFF_K3, c);
    write_reg(REG_COEFF_K4, d);
  endtask

  function automatic logic [31:0] small_coeff();
    return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset lens: zero radius, extremes, axes
    send_point(32'h0, 32'h0);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h7fff_ffff, 32'h0);
    send_point(32'h0, 32'h8000_0000);
    send_point(32'h1, 32'h0);
    send_point(32'h0, 32'hffff_ffff);
    send_point(32'h0100_0000, 32'hff00_0000);
    drain();

    // extreme lens, unmapped index must be ignored
    load_lens(32'hffff_ffff, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    write_reg(REG_UNMAPPED, 32'h1234_5678);
    send_point(32'h0, 32'h0);
    send_point(32'h0100_0000, 32'h0100_0000);
    send_point(32'h8000_0000, 32'h7fff_ffff);
    send_point(32'hff00_0000, 32'h0000_0001);
    send_point(32'h0000_1000, 32'hfff0_0000);
    drain();
    load_lens(32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h0, 32'h0);
    send_point(32'h0200_0000, 32'hfe00_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      tx_idle = phase < 2 ? 11 : (phase < 4 ? 79 : 0);
      rx_idle = phase < 2 ? 79 : (phase < 4 ? 11 : 0);
      if (phase % 3 == 2)
        load_lens($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
      else
        load_lens($urandom_range(32'h0400_0000), $urandom_range(32'h0400_0000),
                  $urandom_range(32'h0400_0000) - 32'h0200_0000,
                  $urandom_range(32'h0400_0000) - 32'h0200_0000,
                  small_coeff(), small_coeff(), small_coeff(), small_coeff());
      for (int n = 0; n < 255; n++) begin
        if (n == 128) drain();
        if ($urandom_range(49) == 0) send_point(32'h0, 32'h0);
        else send_point(rand_coord(), rand_coord());
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
